// ----- src/kvdbc_pkg.sv -----
// Shared types, codes and helpers for the key-value data bit counter.
// No dependencies; used by the top level keyvalue_data_bit_counter.
package kvdbc_pkg;

  // parser position inside a record
  typedef enum logic [1:0] {
    PH_TYPE,
    PH_KEY,
    PH_STRING,
    PH_VALUE
  } phase_t;

  // record kinds as held by the parser
  localparam logic [2:0] KIND_DICT    = 3'd0;
  localparam logic [2:0] KIND_STRING  = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_FLOAT   = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  // special byte values
  localparam logic [7:0] BYTE_NUL       = 8'h00;
  localparam logic [7:0] BYTE_CLOSE     = 8'h08;
  localparam logic [7:0] BYTE_LAST_KIND = 8'h03;

  // end status codes
  localparam logic [1:0] ST_TOP_CLOSE    = 2'd0;
  localparam logic [1:0] ST_END_OF_DATA  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN_TOP  = 2'd2;
  localparam logic [1:0] ST_DEPTH_OVFL   = 2'd3;

  // length of the matched key "data"
  localparam logic [2:0] KEY_LEN = 3'd4;

  // result payload widths
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 24;

  // characters of the key "data"
  function automatic logic [7:0] key_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h64;
      2'd1: c = 8'h61;
      2'd2: c = 8'h74;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  // number of set bits in a byte
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

endpackage

// ----- src/kvdbc_skid.sv -----
// Two-entry output register with skid stage for a valid/ready stream.
// No dependencies; used by the top level keyvalue_data_bit_counter.
module kvdbc_skid #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH-1:0] up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH-1:0] dn_data
);

  logic             main_valid_r;
  logic [WIDTH-1:0] main_data_r;
  logic             skid_valid_r;
  logic [WIDTH-1:0] skid_data_r;
  logic             up_fire;
  logic             main_free;

  // ready only depends on the skid slot, so it is registered
  assign up_ready  = !skid_valid_r;
  assign up_fire   = up_valid && up_ready;
  assign main_free = dn_ready || !main_valid_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || up_fire;
      skid_valid_r <= 1'b0;
    end else if (up_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_valid_r ? skid_data_r : up_data;
    end else if (up_fire) begin
      skid_data_r <= up_data;
    end
  end

  assign dn_valid = main_valid_r;
  assign dn_data  = main_data_r;

endmodule

// ----- src/keyvalue_data_bit_counter.sv -----
// Top level of the key-value data bit counter: byte parser and result output.
// Depends on kvdbc_pkg and kvdbc_skid.

// Takes a binary key-value file one byte per transfer (tlast on the file's
// final byte) at one byte per cycle. Each byte updates the registered parser
// state; the byte that ends the parse, or the last byte, produces one result
// transfer, which is registered in the output stage. A two-entry output stage
// lets input keep flowing while a result waits; input stalls only when both
// output entries are full. Nesting is limited by MAX_DEPTH. After the last
// byte all parser state returns to reset values.
module keyvalue_data_bit_counter #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] bit_total, [17:16] end_status, zero pad
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  kvdbc_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic [2:0]          match_idx_r, match_idx_nxt;
  logic                mismatch_r, mismatch_nxt;
  logic [1:0]          val_cnt_r, val_cnt_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [15:0]         total_r, total_nxt;
  logic                done_r, done_nxt;
  logic [5:0]          pending_r, pending_nxt;

  logic                in_fire;
  logic                finish;
  logic [1:0]          finish_code;
  logic                emit;
  logic [1:0]          emit_code;
  logic [16:0]         sum;
  logic [5:0]          pend_add;
  logic [kvdbc_pkg::OUT_W-1:0] res_data;

  assign in_fire = in_tvalid && in_tready;

  // per-byte parser update
  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    match_idx_nxt = match_idx_r;
    mismatch_nxt  = mismatch_r;
    val_cnt_nxt   = val_cnt_r;
    depth_nxt     = depth_r;
    total_nxt     = total_r;
    done_nxt      = done_r;
    pending_nxt   = pending_r;
    finish        = 1'b0;
    finish_code   = kvdbc_pkg::ST_TOP_CLOSE;
    pend_add      = pending_r;
    sum           = {1'b0, total_r};

    if (!done_r) begin
      unique case (phase_r)
        kvdbc_pkg::PH_TYPE: begin
          if (in_tdata == kvdbc_pkg::BYTE_CLOSE) begin
            if (depth_r == '0) begin
              finish      = 1'b1;
              finish_code = kvdbc_pkg::ST_TOP_CLOSE;
            end else begin
              depth_nxt = depth_r - DEPTH_W'(1);
              phase_nxt = kvdbc_pkg::PH_TYPE;
            end
          end else begin
            kind_nxt      = (in_tdata <= kvdbc_pkg::BYTE_LAST_KIND) ? in_tdata[2:0]
                                                                   : kvdbc_pkg::KIND_UNKNOWN;
            match_idx_nxt = 3'd0;
            mismatch_nxt  = 1'b0;
            phase_nxt     = kvdbc_pkg::PH_KEY;
          end
        end
        kvdbc_pkg::PH_KEY: begin
          if (in_tdata != kvdbc_pkg::BYTE_NUL) begin
            // track the match against "data"
            if (match_idx_r < kvdbc_pkg::KEY_LEN &&
                in_tdata == kvdbc_pkg::key_char(match_idx_r[1:0])) begin
              match_idx_nxt = match_idx_r + 3'd1;
            end else begin
              mismatch_nxt = 1'b1;
            end
          end else begin
            // key complete: act on the record kind
            unique case (kind_r)
              kvdbc_pkg::KIND_DICT: begin
                if (depth_r >= DEPTH_W'(MAX_DEPTH)) begin
                  finish      = 1'b1;
                  finish_code = kvdbc_pkg::ST_DEPTH_OVFL;
                end else begin
                  depth_nxt = depth_r + DEPTH_W'(1);
                  phase_nxt = kvdbc_pkg::PH_TYPE;
                end
              end
              kvdbc_pkg::KIND_STRING: begin
                phase_nxt = kvdbc_pkg::PH_STRING;
              end
              kvdbc_pkg::KIND_INT, kvdbc_pkg::KIND_FLOAT: begin
                val_cnt_nxt = 2'd0;
                pending_nxt = 6'd0;
                phase_nxt   = kvdbc_pkg::PH_VALUE;
              end
              default: begin
                // unknown type ends the current level
                if (depth_r == '0) begin
                  finish      = 1'b1;
                  finish_code = kvdbc_pkg::ST_UNKNOWN_TOP;
                end else begin
                  depth_nxt = depth_r - DEPTH_W'(1);
                  phase_nxt = kvdbc_pkg::PH_TYPE;
                end
              end
            endcase
          end
        end
        kvdbc_pkg::PH_STRING: begin
          if (in_tdata == kvdbc_pkg::BYTE_NUL) begin
            phase_nxt = kvdbc_pkg::PH_TYPE;
          end
        end
        default: begin
          // value bytes: count bits only for a matched integer
          if (kind_r == kvdbc_pkg::KIND_INT && !mismatch_r &&
              match_idx_r == kvdbc_pkg::KEY_LEN) begin
            pend_add = pending_r + {2'd0, kvdbc_pkg::popcount8(in_tdata)};
          end
          if (val_cnt_r == 2'd3) begin
            sum         = {1'b0, total_r} + {11'd0, pend_add};
            total_nxt   = sum[16] ? 16'hFFFF : sum[15:0];
            pending_nxt = 6'd0;
            val_cnt_nxt = 2'd0;
            phase_nxt   = kvdbc_pkg::PH_TYPE;
          end else begin
            pending_nxt = pend_add;
            val_cnt_nxt = val_cnt_r + 2'd1;
          end
        end
      endcase
    end

    if (finish) begin
      done_nxt = 1'b1;
    end
  end

  // result decision
  assign emit      = in_fire && !done_r && (finish || in_tlast);
  assign emit_code = finish ? finish_code : kvdbc_pkg::ST_END_OF_DATA;
  assign res_data  = {6'd0, emit_code, total_nxt};

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_tlast)) begin
      phase_r     <= kvdbc_pkg::PH_TYPE;
      kind_r      <= 3'd0;
      match_idx_r <= 3'd0;
      mismatch_r  <= 1'b0;
      val_cnt_r   <= 2'd0;
      depth_r     <= '0;
      total_r     <= 16'd0;
      done_r      <= 1'b0;
      pending_r   <= 6'd0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      match_idx_r <= match_idx_nxt;
      mismatch_r  <= mismatch_nxt;
      val_cnt_r   <= val_cnt_nxt;
      depth_r     <= depth_nxt;
      total_r     <= total_nxt;
      done_r      <= done_nxt;
      pending_r   <= pending_nxt;
    end
  end

  // result output stage
  kvdbc_skid #(
    .WIDTH(kvdbc_pkg::OUT_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (emit),
    .up_ready (in_tready),
    .up_data  (res_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata)
  );

  // depth never passes the configured limit
  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("nest depth beyond limit");

  // a last byte always clears the parser for the next file
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> !done_r && depth_r == '0 && total_r == 16'd0)
    else $error("parser not cleared after last byte");

  // a live parse always reports on its last byte
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast && !done_r |-> emit)
    else $error("no result on last byte");

  // nothing is reported once the parse has ended
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !emit)
    else $error("result after parse end");

  // pending bit count covers at most three bytes and is zero outside a value
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 6'd24 && (phase_r == kvdbc_pkg::PH_VALUE || pending_r == 6'd0))
    else $error("pending bit count out of range");

endmodule

// ----- tb/sv/kvdbc_total_checker.sv -----
// Checker for the key-value data bit counter: follows the byte stream, predicts
// each bit total and end status, and compares them with the result transfers.
// Depends on kvdbc_pkg.
module kvdbc_total_checker #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          mismatch_count,
  output int          totals_due
);

  typedef struct packed {
    logic [kvdbc_pkg::TOTAL_W-1:0]  total;
    logic [kvdbc_pkg::STATUS_W-1:0] status;
  } file_result_t;

  localparam logic [31:0] DATA_KEY = "data";

  // parser copy
  kvdbc_pkg::phase_t phase;
  logic [2:0]  kind;
  logic [2:0]  key_pos;
  logic        key_bad;
  logic [1:0]  val_cnt;
  logic [4:0]  depth;
  logic [15:0] total;
  logic        done;
  logic [5:0]  pend_bits;

  // per byte emission
  logic        emit;
  logic [1:0]  emit_code;

  file_result_t expected_totals[$];
  file_result_t seen;
  int           mismatches = 0;

  task automatic clear_parser();
    phase     = kvdbc_pkg::PH_TYPE;
    kind      = kvdbc_pkg::KIND_DICT;
    key_pos   = '0;
    key_bad   = 1'b0;
    val_cnt   = '0;
    depth     = '0;
    total     = '0;
    done      = 1'b0;
    pend_bits = '0;
  endtask

  task automatic finish_parse(input logic [1:0] code);
    done      = 1'b1;
    emit      = 1'b1;
    emit_code = code;
  endtask

  // close byte or unknown type: pop a level, or end the parse at the top
  task automatic close_level(input logic [1:0] top_code);
    if (depth == 0) begin
      finish_parse(top_code);
    end else begin
      depth = depth - 5'd1;
      phase = kvdbc_pkg::PH_TYPE;
    end
  endtask

  task automatic count_byte(input logic [7:0] b, input logic last);
    logic [16:0] sum;
    logic        was_done;
    was_done  = done;
    emit      = 1'b0;
    emit_code = kvdbc_pkg::ST_TOP_CLOSE;
    if (!was_done) begin
      case (phase)
        kvdbc_pkg::PH_TYPE: begin
          if (b == kvdbc_pkg::BYTE_CLOSE) begin
            close_level(kvdbc_pkg::ST_TOP_CLOSE);
          end else begin
            kind    = (b <= kvdbc_pkg::BYTE_LAST_KIND) ? b[2:0] : kvdbc_pkg::KIND_UNKNOWN;
            key_pos = '0;
            key_bad = 1'b0;
            phase   = kvdbc_pkg::PH_KEY;
          end
        end
        kvdbc_pkg::PH_KEY: begin
          if (b != kvdbc_pkg::BYTE_NUL) begin
            // key must spell the word exactly, no more and no less
            if (key_pos < kvdbc_pkg::KEY_LEN && b == DATA_KEY[8*(3 - key_pos) +: 8]) begin
              key_pos = key_pos + 3'd1;
            end else begin
              key_bad = 1'b1;
            end
          end else begin
            case (kind)
              kvdbc_pkg::KIND_DICT: begin
                if (depth >= MAX_DEPTH) begin
                  finish_parse(kvdbc_pkg::ST_DEPTH_OVFL);
                end else begin
                  depth = depth + 5'd1;
                  phase = kvdbc_pkg::PH_TYPE;
                end
              end
              kvdbc_pkg::KIND_STRING: begin
                phase = kvdbc_pkg::PH_STRING;
              end
              kvdbc_pkg::KIND_INT, kvdbc_pkg::KIND_FLOAT: begin
                val_cnt   = '0;
                pend_bits = '0;
                phase     = kvdbc_pkg::PH_VALUE;
              end
              default: begin
                close_level(kvdbc_pkg::ST_UNKNOWN_TOP);
              end
            endcase
          end
        end
        kvdbc_pkg::PH_STRING: begin
          if (b == kvdbc_pkg::BYTE_NUL) phase = kvdbc_pkg::PH_TYPE;
        end
        default: begin
          // bits only count once the fourth value byte is in
          if (kind == kvdbc_pkg::KIND_INT && !key_bad && key_pos == kvdbc_pkg::KEY_LEN) begin
            pend_bits = pend_bits + 6'($countones(b));
          end
          if (val_cnt == 2'd3) begin
            sum       = {1'b0, total} + {11'd0, pend_bits};
            total     = sum[16] ? 16'hFFFF : sum[15:0];
            pend_bits = '0;
            val_cnt   = '0;
            phase     = kvdbc_pkg::PH_TYPE;
          end else begin
            val_cnt = val_cnt + 2'd1;
          end
        end
      endcase
    end
    if (last && !was_done && !emit) begin
      emit      = 1'b1;
      emit_code = kvdbc_pkg::ST_END_OF_DATA;
    end
    if (emit) expected_totals.push_back('{total, emit_code});
    if (last) clear_parser();
  endtask

  // predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_totals.delete();
    end else begin
      if (in_tvalid && in_tready) count_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_totals.size() == 0) begin
          $error("unexpected result: bit_total %0d, end_status %0d",
                 out_tdata[15:0], out_tdata[17:16]);
          mismatches++;
        end else begin
          seen = expected_totals.pop_front();
          if (out_tdata[15:0] !== seen.total) begin
            $error("bit_total mismatch: expected %0d, actual %0d",
                   seen.total, out_tdata[15:0]);
            mismatches++;
          end
          if (out_tdata[17:16] !== seen.status) begin
            $error("end_status mismatch: expected %0d, actual %0d",
                   seen.status, out_tdata[17:16]);
            mismatches++;
          end
          if (out_tdata[23:18] !== 6'd0) begin
            $error("tdata pad mismatch: expected %0d, actual %0d", 0, out_tdata[23:18]);
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    totals_due     <= expected_totals.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the key-value data bit counter: builds key-value files
// byte by byte, drives both stream sides with random idling and gives the verdict.
// Depends on kvdbc_pkg, keyvalue_data_bit_counter and kvdbc_total_checker.
module tb;

  localparam int MAX_DEPTH    = 16;
  localparam int MAX_IDLE     = 11;
  localparam int RANDOM_BYTES = 800;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  int          mismatch_count;
  int          totals_due;
  int unsigned cycle_count = 0;
  int          bytes_sent = 0;
  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  logic        tx_eager = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic [7:0]  file_bytes[$];

  keyvalue_data_bit_counter #(
    .MAX_DEPTH(MAX_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  kvdbc_total_checker #(
    .MAX_DEPTH(MAX_DEPTH)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .totals_due    (totals_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      gap = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // one byte transfer, after a random idle stretch
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
    gap = (tx_idle && !tx_eager) ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    file_bytes.delete();
  endtask

  // key: mostly "data", else a prefix, a longer word or random text
  task automatic push_key();
    int r;
    int len;
    r   = $urandom_range(0, 5);
    len = (r == 3) ? $urandom_range(0, 3) : 4;
    if (r <= 4) begin
      for (int i = 0; i < len; i++) file_bytes.push_back(kvdbc_pkg::key_char(2'(i)));
    end
    if (r == 4) file_bytes.push_back(8'($urandom_range(1, 255)));
    if (r == 5) repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom_range(1, 255)));
    file_bytes.push_back(kvdbc_pkg::BYTE_NUL);
  endtask

  // value byte leaning toward all ones and all zeros
  function automatic logic [7:0] value_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return v;
  endfunction

  // one non-dictionary record
  task automatic push_record();
    int         r;
    logic [7:0] t;
    r = $urandom_range(0, 9);
    if (r <= 4) begin
      file_bytes.push_back({5'd0, kvdbc_pkg::KIND_INT});
      push_key();
      repeat (4) file_bytes.push_back(value_byte());
    end else if (r <= 6) begin
      file_bytes.push_back({5'd0, kvdbc_pkg::KIND_FLOAT});
      push_key();
      repeat (4) file_bytes.push_back(value_byte());
    end else if (r <= 8) begin
      file_bytes.push_back({5'd0, kvdbc_pkg::KIND_STRING});
      push_key();
      repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(1, 255)));
      file_bytes.push_back(kvdbc_pkg::BYTE_NUL);
    end else begin
      do t = 8'($urandom_range(4, 255)); while (t == kvdbc_pkg::BYTE_CLOSE);
      file_bytes.push_back(t);
      push_key();
    end
  endtask

  task automatic build_random_file();
    int style;
    int n;
    int depth;
    int cut;
    style = $urandom_range(0, 11);
    if (style == 0) begin
      // plain noise
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (style == 1) begin
      // deep nesting around the depth limit
      n = $urandom_range(MAX_DEPTH - 1, MAX_DEPTH + 2);
      repeat (n) begin
        file_bytes.push_back({5'd0, kvdbc_pkg::KIND_DICT});
        push_key();
      end
      push_record();
      repeat (n + 1) file_bytes.push_back(kvdbc_pkg::BYTE_CLOSE);
    end else begin
      // well-formed nested records
      depth = 0;
      repeat ($urandom_range(1, 10)) begin
        n = $urandom_range(0, 9);
        if (n == 0 && depth < 3) begin
          file_bytes.push_back({5'd0, kvdbc_pkg::KIND_DICT});
          push_key();
          depth++;
        end else if (n == 1 && depth > 0) begin
          file_bytes.push_back(kvdbc_pkg::BYTE_CLOSE);
          depth--;
        end else begin
          push_record();
        end
      end
      repeat (depth + 1) file_bytes.push_back(kvdbc_pkg::BYTE_CLOSE);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // broken files: cut short anywhere
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  // stimulus and verdict
  initial begin
    int goal;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // close at top level on the last byte
    file_bytes = '{kvdbc_pkg::BYTE_CLOSE};
    send_file();
    // counted data integer with all bits set, then top close
    file_bytes = '{8'h02, 8'h64, 8'h61, 8'h74, 8'h61, 8'h00,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, kvdbc_pkg::BYTE_CLOSE};
    send_file();
    // empty keys, dictionary and string, then unknown type cut by the last byte
    file_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, kvdbc_pkg::BYTE_CLOSE, 8'hFF};
    send_file();
    // unknown type at top level ends on the last byte
    file_bytes = '{8'hFF, 8'h00};
    send_file();
    // float with zero value, early top close, trailing byte ignored
    file_bytes = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, kvdbc_pkg::BYTE_CLOSE, 8'h55};
    send_file();
    // truncated data value is not counted
    file_bytes = '{8'h02, 8'h64, 8'h61, 8'h74, 8'h61, 8'h00, 8'hFF};
    send_file();

    // back pressure: long result hold-off while one-byte files keep coming
    hold_req = 1'b1;
    tx_eager = 1'b1;
    repeat (12) begin
      file_bytes = '{8'($urandom_range(0, 255))};
      send_file();
    end
    tx_eager = 1'b0;

    // random files
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      build_random_file();
      send_file();
    end

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    @(posedge clk);
    while (totals_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && totals_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
